// ===== rtl/core/v4a_pkg.sv =====
// Shared types, opcodes and arithmetic step functions for the four-lane vector ALU.
package v4a_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int LANES         = 4;
    localparam int NPROD         = 8;
    localparam int ROOT_BITS     = 33;
    localparam int SQ_BITS       = 66;
    localparam int QUO_BITS      = 33;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_MUL    = 4'd2,
        OP_DIV    = 4'd3,
        OP_SCALE  = 4'd4,
        OP_DOT    = 4'd5,
        OP_CROSS3 = 4'd6,
        OP_CROSS4 = 4'd7,
        OP_LENGTH = 4'd8,
        OP_NORM   = 4'd9
    } op_t;

    typedef logic [LANES-1:0][31:0] vec_t;

    // One word as it travels down the pipe; later stages ignore what they do not need.
    typedef struct packed {
        logic [3:0]                       op;
        vec_t                             a;
        vec_t                             b;
        logic [31:0]                      f;
        logic [NPROD-1:0][63:0]           prod;
        vec_t                             res;
        logic [31:0]                      sc;
        logic                             dz;
        logic [SQ_BITS-1:0]               sq;
        logic [34:0]                      srem;
        logic [ROOT_BITS-1:0]             root;
        logic [LANES-1:0][32:0]           drem;
        logic [LANES-1:0][QUO_BITS-1:0]   nlo;
        logic [LANES-1:0][32:0]           den;
        logic [LANES-1:0][QUO_BITS-1:0]   quo;
        logic [LANES-1:0]                 ovf;
        logic [LANES-1:0]                 neg;
        logic [LANES-1:0]                 dzl;
    } item_t;

    function automatic logic [31:0] sat66(input logic signed [65:0] v);
        if (v > 66'sh0_0000_0000_7FFF_FFFF)
            return Q_MAX;
        else if (v < 66'sh3_FFFF_FFFF_8000_0000)
            return Q_MIN;
        else
            return v[31:0];
    endfunction

    // One root bit per call: bring in the next radicand pair, try (root<<2)|1.
    function automatic item_t sqrt_step(input item_t it);
        item_t       r;
        logic [36:0] w;
        logic [36:0] t;
        r = it;
        w = {it.srem, it.sq[SQ_BITS-1:SQ_BITS-2]};
        t = {2'b00, it.root, 2'b01};
        if (w >= t)
        begin
            r.srem = 35'(w - t);
            r.root = {it.root[ROOT_BITS-2:0], 1'b1};
        end
        else
        begin
            r.srem = w[34:0];
            r.root = {it.root[ROOT_BITS-2:0], 1'b0};
        end
        r.sq = {it.sq[SQ_BITS-3:0], 2'b00};
        return r;
    endfunction

    // One restoring quotient bit per lane per call.
    function automatic item_t div_step(input item_t it);
        item_t       r;
        logic [33:0] w;
        logic [33:0] d;
        logic        qb;
        r = it;
        for (int i = 0; i < LANES; i++)
        begin
            w  = {it.drem[i], it.nlo[i][QUO_BITS-1]};
            d  = {1'b0, it.den[i]};
            qb = (w >= d);
            if (qb)
                r.drem[i] = 33'(w - d);
            else
                r.drem[i] = w[32:0];
            r.nlo[i] = {it.nlo[i][QUO_BITS-2:0], 1'b0};
            r.quo[i] = {it.quo[i][QUO_BITS-2:0], qb};
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/vec4_vector_alu.sv =====
// Top level of the four-lane Q16.16 vector ALU with stream ports.
//
// Four-lane signed fixed-point vector unit. Each input word carries an opcode
// (add, sub, mul, div, scale, dot, cross3, cross4, length, normalize) and two
// vectors plus a scalar; each produces exactly one result word, in order. The
// pipe is fully pipelined: a new word may enter every cycle and one result
// leaves per cycle while the downstream side is ready. A word passes
// 3 + 33 + 1 + 33 + 1 = 71 register stages for every opcode: three front
// stages (input register, eight 32x32 multipliers, product combine and
// saturation), 33 square-root stages (one root bit each), one divider setup
// stage, 33 restoring divider stages (one quotient bit per lane each) and the
// output register. Each stage has its own valid bit and can fill while later
// stages stall, so bubbles are squeezed out and a held result does not stop
// intake until the pipe is full. Overflow saturates; a zero divisor, or
// normalising a zero vector, saturates by the dividend's sign and raises
// div_zero.
module vec4_vector_alu
    import v4a_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [287:0] s_tdata,   // ax, ay, az, aw, bx, by, bz, bw, factor
    input  logic [3:0]   s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // rx, ry, rz, rw, scalar_out
    output logic [0:0]   m_tuser    // div_zero
);

    item_t s0_reg, s0_next;
    item_t s1_reg, s1_next;
    item_t s2_reg, s2_next;
    logic  v0_reg, v1_reg, v2_reg;
    logic  en0, en1, en2;

    logic  rd_ready;
    logic  rd_valid;
    item_t rd_item;

    logic [159:0] out_reg, out_next;
    logic         dz_reg, dz_next;
    logic         ov_reg;
    logic         out_en;

    // ---- stage 0: capture the input word ----
    always_comb
    begin
        s0_next    = '0;
        s0_next.op = s_tuser;
        for (int i = 0; i < LANES; i++)
        begin
            s0_next.a[i] = s_tdata[32*i +: 32];
            s0_next.b[i] = s_tdata[32*(i+LANES) +: 32];
        end
        s0_next.f = s_tdata[256 +: 32];
    end

    // ---- stage 1: operand routing, multipliers, add and sub ----
    logic signed [31:0] mx [NPROD];
    logic signed [31:0] my [NPROD];
    logic signed [32:0] addsub;

    always_comb
    begin
        s1_next = s0_reg;
        for (int k = 0; k < NPROD; k++)
        begin
            mx[k] = '0;
            my[k] = '0;
        end
        for (int i = 0; i < LANES; i++)
        begin
            mx[i] = s0_reg.a[i];
            my[i] = s0_reg.b[i];
        end
        unique case (op_t'(s0_reg.op))
            OP_SCALE:
            begin
                for (int i = 0; i < LANES; i++)
                    my[i] = s0_reg.f;
            end
            OP_LENGTH, OP_NORM:
            begin
                for (int i = 0; i < LANES; i++)
                    my[i] = s0_reg.a[i];
            end
            OP_CROSS3, OP_CROSS4:
            begin
                // x: ay*bz - az*by
                mx[0] = s0_reg.a[1];  my[0] = s0_reg.b[2];
                mx[4] = s0_reg.a[2];  my[4] = s0_reg.b[1];
                if (s0_reg.op == OP_CROSS3)
                begin
                    mx[1] = s0_reg.a[2];  my[1] = s0_reg.b[0];
                    mx[5] = s0_reg.a[0];  my[5] = s0_reg.b[2];
                    mx[2] = s0_reg.a[0];  my[2] = s0_reg.b[1];
                    mx[6] = s0_reg.a[1];  my[6] = s0_reg.b[0];
                    mx[3] = '0;           my[3] = '0;
                end
                else
                begin
                    // wrap-around: y and z each use the w of both a and b
                    mx[1] = s0_reg.a[2];  my[1] = s0_reg.b[3];
                    mx[5] = s0_reg.a[3];  my[5] = s0_reg.b[2];
                    mx[2] = s0_reg.a[3];  my[2] = s0_reg.b[0];
                    mx[6] = s0_reg.a[0];  my[6] = s0_reg.b[3];
                    mx[3] = s0_reg.a[0];  my[3] = s0_reg.b[1];
                    mx[7] = s0_reg.a[1];  my[7] = s0_reg.b[0];
                end
            end
            default:
            begin
            end
        endcase
        for (int k = 0; k < NPROD; k++)
            s1_next.prod[k] = mx[k] * my[k];

        for (int i = 0; i < LANES; i++)
        begin
            if (s0_reg.op == OP_SUB)
                addsub = $signed({s0_reg.a[i][31], s0_reg.a[i]})
                       - $signed({s0_reg.b[i][31], s0_reg.b[i]});
            else
                addsub = $signed({s0_reg.a[i][31], s0_reg.a[i]})
                       + $signed({s0_reg.b[i][31], s0_reg.b[i]});
            if (s0_reg.op == OP_ADD || s0_reg.op == OP_SUB)
                s1_next.res[i] = sat66(66'(addsub));
            else
                s1_next.res[i] = '0;
        end
    end

    // ---- stage 2: combine products, shift back to Qn, saturate ----
    logic signed [65:0] pw [NPROD];
    logic signed [65:0] lane_sum;
    logic signed [65:0] dot_sum;

    always_comb
    begin
        s2_next = s1_reg;
        for (int k = 0; k < NPROD; k++)
            pw[k] = 66'($signed(s1_reg.prod[k]));
        dot_sum = pw[0] + pw[1] + pw[2] + pw[3];
        // squares are never negative, so the same sum feeds the root
        s2_next.sq   = dot_sum;
        s2_next.srem = '0;
        s2_next.root = '0;
        for (int i = 0; i < LANES; i++)
        begin
            lane_sum = pw[i] - pw[i+LANES];
            if (s1_reg.op == OP_MUL || s1_reg.op == OP_SCALE
                || s1_reg.op == OP_CROSS4)
                s2_next.res[i] = sat66(lane_sum >>> FRAC_BITS);
            else if (s1_reg.op == OP_CROSS3 && i != LANES-1)
                s2_next.res[i] = sat66(lane_sum >>> FRAC_BITS);
            else if (s1_reg.op == OP_ADD || s1_reg.op == OP_SUB)
                s2_next.res[i] = s1_reg.res[i];
            else
                s2_next.res[i] = '0;
        end
        if (s1_reg.op == OP_DOT)
            s2_next.sc = sat66(dot_sum >>> FRAC_BITS);
        else
            s2_next.sc = '0;
        s2_next.dz = 1'b0;
    end

    // ---- front handshake: each stage loads when empty or moving on ----
    assign en2      = !v2_reg || rd_ready;
    assign en1      = !v1_reg || en2;
    assign en0      = !v0_reg || en1;
    assign s_tready = en0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en0)
                v0_reg <= s_tvalid;
            if (en1)
                v1_reg <= v0_reg;
            if (en2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0)
            s0_reg <= s0_next;
        if (en1)
            s1_reg <= s1_next;
        if (en2)
            s2_reg <= s2_next;
    end

    // ---- root and divider pipe ----
    v4a_root_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_root_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .in_ready  (rd_ready),
        .in_item   (s2_reg),
        .out_valid (rd_valid),
        .out_ready (out_en),
        .out_item  (rd_item)
    );

    // ---- output stage: sign and saturate quotients, pack the word ----
    logic [31:0] lane_q;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (rd_item.dzl[i])
            begin
                if (rd_item.a[i] == 32'd0)
                    lane_q = '0;
                else if (rd_item.a[i][31])
                    lane_q = Q_MIN;
                else
                    lane_q = Q_MAX;
            end
            else if (rd_item.ovf[i])
                lane_q = rd_item.neg[i] ? Q_MIN : Q_MAX;
            else if (rd_item.neg[i])
                lane_q = (rd_item.quo[i] > 33'h0_8000_0000) ? Q_MIN
                                                            : 32'(-rd_item.quo[i]);
            else
                lane_q = (rd_item.quo[i] > 33'h0_7FFF_FFFF) ? Q_MAX
                                                            : rd_item.quo[i][31:0];

            if (rd_item.op == OP_DIV || rd_item.op == OP_NORM)
                out_next[32*i +: 32] = lane_q;
            else
                out_next[32*i +: 32] = rd_item.res[i];
        end
        out_next[128 +: 32] = rd_item.sc;
        dz_next             = rd_item.dz;
    end

    assign out_en = !ov_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (out_en)
            ov_reg <= rd_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            out_reg <= out_next;
            dz_reg  <= dz_next;
        end
    end

    assign m_tvalid   = ov_reg;
    assign m_tdata    = out_reg;
    assign m_tuser[0] = dz_reg;

endmodule

// ===== rtl/core/v4a_root_div.sv =====
// Pipelined integer square root followed by a four-lane pipelined divider.
module v4a_root_div
    import v4a_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    localparam int NW  = 32 + FRAC_BITS;
    localparam int NST = ROOT_BITS + 1 + QUO_BITS;

    // Pick divisor per lane, range check and load the divider; also set div_zero and the length scalar.
    function automatic item_t div_setup(input item_t it);
        item_t             r;
        logic              dv;
        logic              nm;
        logic              sa;
        logic              sb;
        logic [31:0]       mag;
        logic [31:0]       bmag;
        logic [32:0]       dn;
        logic [NW-1:0]     num;
        logic [65:0]       num_w;
        logic [65:0]       lim;
        r  = it;
        dv = (it.op == OP_DIV);
        nm = (it.op == OP_NORM);
        for (int i = 0; i < LANES; i++)
        begin
            sa    = it.a[i][31];
            sb    = it.b[i][31];
            mag   = sa ? 32'(-it.a[i]) : it.a[i];
            bmag  = sb ? 32'(-it.b[i]) : it.b[i];
            dn    = dv ? {1'b0, bmag} : it.root;
            num   = {mag, {FRAC_BITS{1'b0}}};
            num_w = 66'(num);
            lim   = {dn, {QUO_BITS{1'b0}}};
            r.ovf[i]  = (num_w >= lim);
            r.drem[i] = 33'(num_w >> QUO_BITS);
            r.nlo[i]  = num_w[QUO_BITS-1:0];
            r.den[i]  = dn;
            r.quo[i]  = '0;
            r.neg[i]  = sa ^ (dv & sb);
            r.dzl[i]  = (dn == 33'd0);
        end
        if (dv || nm)
            r.dz = |r.dzl;
        if (nm || (it.op == OP_LENGTH))
            r.sc = (|it.root[32:31]) ? Q_MAX : it.root[31:0];
        return r;
    endfunction

    item_t            stage_reg [NST];
    item_t            stage_in  [NST];
    item_t            stage_next[NST];
    logic [NST-1:0]   valid_reg;
    logic [NST-1:0]   valid_in;
    logic [NST:0]     en;

    assign en[NST] = out_ready;

    for (genvar k = 0; k < NST; k++)
    begin : g_stage
        if (k == 0)
        begin : g_first
            assign stage_in[k] = in_item;
            assign valid_in[k] = in_valid;
        end
        else
        begin : g_rest
            assign stage_in[k] = stage_reg[k-1];
            assign valid_in[k] = valid_reg[k-1];
        end

        if (k < ROOT_BITS)
        begin : g_sqrt
            assign stage_next[k] = sqrt_step(stage_in[k]);
        end
        else if (k == ROOT_BITS)
        begin : g_setup
            assign stage_next[k] = div_setup(stage_in[k]);
        end
        else
        begin : g_div
            assign stage_next[k] = div_step(stage_in[k]);
        end

        // a stage may load when empty or when the one after it moves on
        assign en[k] = !valid_reg[k] || en[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en[k])
                valid_reg[k] <= valid_in[k];
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
                stage_reg[k] <= stage_next[k];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NST-1];
    assign out_item  = stage_reg[NST-1];

endmodule

// ===== tb/tb_top.sv =====
// Self-checking stream testbench for the four-lane Q16.16 vector ALU.
`timescale 1ns / 100ps

module tb_top
    import v4a_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 5000;   // cycles with nothing accepted
    localparam int DRAIN_CYCLES   = 100;    // extra wait after the last expected result

    typedef logic signed [127:0] wide_t;

    // one predicted result word
    typedef struct {
        logic signed [31:0] r [4];
        logic signed [31:0] sc;
        logic               dz;
    } alu_res_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [287:0] s_tdata = '0;     // ax, ay, az, aw, bx, by, bz, bw, factor
    logic [3:0]   s_tuser = '0;     // op
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;          // rx, ry, rz, rw, scalar_out
    logic [0:0]   m_tuser;          // div_zero

    alu_res_t pending_res [$];
    int       fail_count = 0;
    int       src_idle_pct = 0;
    int       snk_stall_pct = 0;
    int       quiet_cycles = 0;

    vec4_vector_alu uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ---------------- arithmetic predictor ----------------

    function automatic logic signed [31:0] sat_q(input wide_t v);
        if (v > wide_t'(Q_MAX))
            return Q_MAX;
        else if (v < wide_t'(Q_MIN))
            return Q_MIN;
        return v[31:0];
    endfunction

    // floor square root, result fits 33 bits
    function automatic wide_t root_floor(input wide_t n);
        wide_t r;
        wide_t t;
        r = 0;
        for (int i = 32; i >= 0; i--)
        begin
            t = r | (wide_t'(1) << i);
            if (t * t <= n)
                r = t;
        end
        return r;
    endfunction

    // (num << 16) / den toward zero; zero divisor saturates by sign
    function automatic logic signed [31:0] q_divide(input wide_t num, input wide_t den,
                                                    inout logic dz);
        if (den == 0)
        begin
            dz = 1'b1;
            if (num > 0)
                return Q_MAX;
            else if (num < 0)
                return Q_MIN;
            return 0;
        end
        return sat_q((num <<< 16) / den);
    endfunction

    function automatic alu_res_t predict_alu(input logic [3:0] op, input logic [287:0] d);
        alu_res_t res;
        wide_t    a [4];
        wide_t    b [4];
        wide_t    f;
        wide_t    acc;
        logic     dz;
        logic signed [31:0] w;
        dz = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            w    = d[32*i +: 32];
            a[i] = w;
            w    = d[32*(i+4) +: 32];
            b[i] = w;
            res.r[i] = 0;
        end
        w = d[256 +: 32];
        f = w;
        res.sc = 0;
        case (op)
            OP_ADD:
                for (int i = 0; i < 4; i++) res.r[i] = sat_q(a[i] + b[i]);
            OP_SUB:
                for (int i = 0; i < 4; i++) res.r[i] = sat_q(a[i] - b[i]);
            OP_MUL:
                for (int i = 0; i < 4; i++) res.r[i] = sat_q((a[i] * b[i]) >>> 16);
            OP_DIV:
                for (int i = 0; i < 4; i++) res.r[i] = q_divide(a[i], b[i], dz);
            OP_SCALE:
                for (int i = 0; i < 4; i++) res.r[i] = sat_q((a[i] * f) >>> 16);
            OP_DOT:
            begin
                acc = 0;
                for (int i = 0; i < 4; i++) acc += a[i] * b[i];
                res.sc = sat_q(acc >>> 16);
            end
            OP_CROSS3:
            begin
                res.r[0] = sat_q((a[1]*b[2] - a[2]*b[1]) >>> 16);
                res.r[1] = sat_q((a[2]*b[0] - a[0]*b[2]) >>> 16);
                res.r[2] = sat_q((a[0]*b[1] - a[1]*b[0]) >>> 16);
            end
            OP_CROSS4:
            begin
                res.r[0] = sat_q((a[1]*b[2] - a[2]*b[1]) >>> 16);
                res.r[1] = sat_q((a[2]*b[3] - a[3]*b[2]) >>> 16);
                res.r[2] = sat_q((a[3]*b[0] - a[0]*b[3]) >>> 16);
                res.r[3] = sat_q((a[0]*b[1] - a[1]*b[0]) >>> 16);
            end
            OP_LENGTH, OP_NORM:
            begin
                acc = 0;
                for (int i = 0; i < 4; i++) acc += a[i] * a[i];
                acc = root_floor(acc);
                res.sc = sat_q(acc);
                if (op == OP_NORM)
                    for (int i = 0; i < 4; i++) res.r[i] = q_divide(a[i], acc, dz);
            end
            default: ;  // undefined opcodes give all zeros
        endcase
        res.dz = dz;
        return res;
    endfunction

    // ---------------- stimulus side ----------------

    // drive one word at the falling edge, hold until accepted
    task automatic send_word(input logic [3:0] op, input logic [31:0] v [9]);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        for (int i = 0; i < 9; i++) s_tdata[32*i +: 32] = v[i];
        s_tuser  = op;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_res.push_back(predict_alu(op, s_tdata));
    endtask

    task automatic drain_pipe();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_res.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2**20)) - 2**19);
            2:
                case ($urandom_range(6))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return 0;
                    3: return 1;
                    4: return 32'hFFFF_FFFF;
                    5: return 32'h0001_0000;
                    default: return 32'hFFFF_0000;
                endcase
            3: return $signed($urandom) >>> $urandom_range(31);
            default: return $urandom & 32'h00FF_FFFF;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] v [9];
        // extremes through every opcode, undefined ones included
        for (int op = 0; op < 16; op++)
        begin
            for (int i = 0; i < 9; i++) v[i] = (op % 2) ? Q_MIN : Q_MAX;
            if (op == OP_DIV) v[4] = Q_MIN;
            send_word(4'(op), v);
        end
        // divide by zero: positive, negative and zero dividends
        v = '{Q_MAX, Q_MIN, 0, 32'h0001_0000, 0, 0, 0, 32'h0002_0000, 0};
        send_word(OP_DIV, v);
        // normalise the zero vector
        v = '{0, 0, 0, 0, 1, 2, 3, 4, 5};
        send_word(OP_NORM, v);
        // longest possible length, sum of squares is 2^64
        v = '{Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0, 0};
        send_word(OP_LENGTH, v);
        send_word(OP_NORM, v);
        // mixed signs near the saturation edges
        v = '{Q_MAX, Q_MIN, 32'hFFFF_FFFF, 1, Q_MIN, Q_MAX, 1, 32'hFFFF_FFFF, Q_MIN};
        send_word(OP_CROSS3, v);
        send_word(OP_CROSS4, v);
        send_word(OP_DOT, v);
        send_word(OP_SCALE, v);
        drain_pipe();
    endtask

    task automatic test_random(input int n_words, input int idle, input int stall);
        logic [31:0] v [9];
        logic [3:0]  op;
        src_idle_pct  = idle;
        snk_stall_pct = stall;
        for (int k = 0; k < n_words; k++)
        begin
            op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10))
                                           : 4'($urandom_range(9));
            for (int i = 0; i < 9; i++) v[i] = rand_q();
            // some zero divisors and zero vectors
            if ($urandom_range(9) == 0) v[4 + $urandom_range(3)] = 0;
            if (op == OP_NORM && $urandom_range(14) == 0)
                for (int i = 0; i < 4; i++) v[i] = 0;
            send_word(op, v);
            // short bursts with no idling at all
            if ($urandom_range(49) == 0)
            begin
                src_idle_pct  = (src_idle_pct == 0) ? idle : 0;
                snk_stall_pct = (snk_stall_pct == 0) ? stall : 0;
            end
        end
        drain_pipe();
    endtask

    // ---------------- result side ----------------

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= snk_stall_pct);

    task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] got);
        if (exp !== got)
        begin
            $error("%s expected %0d got %0d", name, $signed(exp), $signed(got));
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        alu_res_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_res.size() == 0)
            begin
                $error("result word with nothing expected");
                fail_count++;
            end
            else
            begin
                e = pending_res.pop_front();
                check_field("rx", e.r[0], m_tdata[31:0]);
                check_field("ry", e.r[1], m_tdata[63:32]);
                check_field("rz", e.r[2], m_tdata[95:64]);
                check_field("rw", e.r[3], m_tdata[127:96]);
                check_field("scalar_out", e.sc, m_tdata[159:128]);
                check_field("div_zero", 32'(e.dz), 32'(m_tuser[0]));
            end
        end
    end

    // watchdog: stalled with work outstanding
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (!s_tvalid && pending_res.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(425, 0, 0);
        test_random(425, 47, 0);
        test_random(425, 0, 47);
        test_random(425, 17, 17);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/v4a_pkg.sv
rtl/core/v4a_root_div.sv
rtl/core/vec4_vector_alu.sv
tb/tb_top.sv
